// File: src/hsvrgb_pkg.sv
package hsvrgb_pkg;

  // Hue geometry and fraction scales
  localparam int unsigned HueSpan    = 360;
  localparam int unsigned SectorSpan = 60;
  localparam int unsigned FullScale  = 255;
  localparam int unsigned FineScale  = 15300;  // FullScale * SectorSpan

  // floor(y / 3825) == (y * FineRecip) >> RecipShift for y < 2^20
  // (3825 = FineScale / 4, the dividend is pre-shifted by two)
  localparam int unsigned FineRecip  = 1122868;  // ceil(2^32 / 3825)
  localparam int unsigned RecipShift = 32;

  typedef enum logic [2:0] {
    SecRed     = 3'd0,  // red to yellow
    SecYellow  = 3'd1,  // yellow to green
    SecGreen   = 3'd2,  // green to cyan
    SecCyan    = 3'd3,  // cyan to blue
    SecBlue    = 3'd4,  // blue to magenta
    SecMagenta = 3'd5   // magenta to red
  } sector_e;

  typedef struct packed {
    sector_e    sector;
    logic [5:0] rem;     // hue mod 60
  } hue_split_t;

endpackage

// File: src/hsvrgb_in_if.sv
interface hsvrgb_in_if;
  logic       valid;
  logic       ready;
  logic [8:0] hue;
  logic [7:0] saturation;
  logic [7:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

// File: src/hsvrgb_out_if.sv
interface hsvrgb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: src/hsvrgb_hue_split.sv
module hsvrgb_hue_split (
  input  logic [8:0]             hue_i,
  output hsvrgb_pkg::hue_split_t split_o
);

  logic [8:0] hue_w;
  logic [8:0] base;

  // 360..511 wrap once
  assign hue_w = (hue_i >= 9'(hsvrgb_pkg::HueSpan)) ?
                 (hue_i - 9'(hsvrgb_pkg::HueSpan)) : hue_i;

  always_comb begin
    priority if (hue_w >= 9'(5 * hsvrgb_pkg::SectorSpan)) begin
      split_o.sector = hsvrgb_pkg::SecMagenta;
      base           = 9'(5 * hsvrgb_pkg::SectorSpan);
    end else if (hue_w >= 9'(4 * hsvrgb_pkg::SectorSpan)) begin
      split_o.sector = hsvrgb_pkg::SecBlue;
      base           = 9'(4 * hsvrgb_pkg::SectorSpan);
    end else if (hue_w >= 9'(3 * hsvrgb_pkg::SectorSpan)) begin
      split_o.sector = hsvrgb_pkg::SecCyan;
      base           = 9'(3 * hsvrgb_pkg::SectorSpan);
    end else if (hue_w >= 9'(2 * hsvrgb_pkg::SectorSpan)) begin
      split_o.sector = hsvrgb_pkg::SecGreen;
      base           = 9'(2 * hsvrgb_pkg::SectorSpan);
    end else if (hue_w >= 9'(hsvrgb_pkg::SectorSpan)) begin
      split_o.sector = hsvrgb_pkg::SecYellow;
      base           = 9'(hsvrgb_pkg::SectorSpan);
    end else begin
      split_o.sector = hsvrgb_pkg::SecRed;
      base           = 9'd0;
    end
    split_o.rem = 6'(hue_w - base);
  end

endmodule

// File: src/hsv_to_rgb_converter_core.sv
// HSV to RGB pixel converter. Takes one word per clock (hue in degrees 0..359,
// saturation and value as 8-bit fractions with 255 = 1.0) and returns 8-bit
// red, green and blue, each truncated toward zero; hue 360..511 wraps to
// 0..151. Throughput is one pixel every cycle while out_o.ready is high;
// the result word passes through the five register stages in order: hue
// split, saturation products, value products, reciprocal divide, sector
// mux into the output register. Each stage has its own valid bit and takes
// a new word when it is empty or its successor moves, so bubbles close up
// behind a stalled output and nothing is dropped or repeated. in_i.ready
// depends combinationally on out_o.ready through that stage chain.
module hsv_to_rgb_converter_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  hsvrgb_in_if.sink     in_i,
  hsvrgb_out_if.source  out_o
);

  // Stage enables and valid bits
  logic en1, en2, en3, en4, en5;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  // Stage 1: hue split
  hsvrgb_pkg::hue_split_t split_w;
  hsvrgb_pkg::hue_split_t s1_split_q;
  logic [7:0]             s1_sat_q;
  logic [7:0]             s1_bri_q;

  // Stage 2: shade factors, scaled by 255 (p) or 15300 (q, t)
  logic [5:0]          rem_c;
  logic [13:0]         sr_prod, src_prod;
  logic [7:0]          s2_bri_q;
  logic [7:0]          s2_ap_q;
  logic [13:0]         s2_aq_q, s2_at_q;
  hsvrgb_pkg::sector_e s2_sector_q;

  // Stage 3: value times factor
  logic [15:0]         s3_xp_q;
  logic [21:0]         s3_xq_q, s3_xt_q;
  logic [7:0]          s3_bri_q;
  hsvrgb_pkg::sector_e s3_sector_q;

  // Stage 4: truncating divides
  logic [16:0]         p_sum;
  logic [40:0]         q_prod, t_prod;
  logic [7:0]          s4_p_q, s4_q_q, s4_t_q, s4_bri_q;
  hsvrgb_pkg::sector_e s4_sector_q;

  // Stage 5: output register
  logic [7:0] red_d, green_d, blue_d;
  logic [7:0] red_q, green_q, blue_q;

  assign en5 = !v5_q || out_o.ready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // ---- stage 1 ----
  hsvrgb_hue_split u_hue_split (
    .hue_i   (in_i.hue),
    .split_o (split_w)
  );

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_split_q <= split_w;
      s1_sat_q   <= in_i.saturation;
      s1_bri_q   <= in_i.brightness;
    end
  end

  // ---- stage 2 ----
  // s*r and s*(60-r) both stay at or below 15300
  assign rem_c    = 6'(hsvrgb_pkg::SectorSpan) - s1_split_q.rem;
  assign sr_prod  = 14'(s1_sat_q) * 14'(s1_split_q.rem);
  assign src_prod = 14'(s1_sat_q) * 14'(rem_c);

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_bri_q    <= s1_bri_q;
      s2_ap_q     <= 8'(hsvrgb_pkg::FullScale) - s1_sat_q;
      s2_aq_q     <= 14'(hsvrgb_pkg::FineScale) - sr_prod;
      s2_at_q     <= 14'(hsvrgb_pkg::FineScale) - src_prod;
      s2_sector_q <= s1_split_q.sector;
    end
  end

  // ---- stage 3 ----
  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_xp_q     <= 16'(s2_bri_q) * 16'(s2_ap_q);
      s3_xq_q     <= 22'(s2_bri_q) * 22'(s2_aq_q);
      s3_xt_q     <= 22'(s2_bri_q) * 22'(s2_at_q);
      s3_bri_q    <= s2_bri_q;
      s3_sector_q <= s2_sector_q;
    end
  end

  // ---- stage 4 ----
  // x/255 for 16-bit x: (x + (x >> 8) + 1) >> 8
  assign p_sum = 17'(s3_xp_q) + 17'(s3_xp_q[15:8]) + 17'd1;
  // x/15300 = (x >> 2) / 3825, by a rounded-up reciprocal; exact for x <= 2^22
  assign q_prod = 41'(s3_xq_q[21:2]) * 41'(hsvrgb_pkg::FineRecip);
  assign t_prod = 41'(s3_xt_q[21:2]) * 41'(hsvrgb_pkg::FineRecip);

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_p_q      <= p_sum[15:8];
      s4_q_q      <= q_prod[hsvrgb_pkg::RecipShift +: 8];
      s4_t_q      <= t_prod[hsvrgb_pkg::RecipShift +: 8];
      s4_bri_q    <= s3_bri_q;
      s4_sector_q <= s3_sector_q;
    end
  end

  // ---- stage 5: sector table ----
  always_comb begin
    unique case (s4_sector_q)
      hsvrgb_pkg::SecRed: begin
        red_d = s4_bri_q; green_d = s4_t_q;   blue_d = s4_p_q;
      end
      hsvrgb_pkg::SecYellow: begin
        red_d = s4_q_q;   green_d = s4_bri_q; blue_d = s4_p_q;
      end
      hsvrgb_pkg::SecGreen: begin
        red_d = s4_p_q;   green_d = s4_bri_q; blue_d = s4_t_q;
      end
      hsvrgb_pkg::SecCyan: begin
        red_d = s4_p_q;   green_d = s4_q_q;   blue_d = s4_bri_q;
      end
      hsvrgb_pkg::SecBlue: begin
        red_d = s4_t_q;   green_d = s4_p_q;   blue_d = s4_bri_q;
      end
      default: begin  // magenta to red
        red_d = s4_bri_q; green_d = s4_p_q;   blue_d = s4_q_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign out_o.valid = v5_q;
  assign out_o.red   = red_q;
  assign out_o.green = green_q;
  assign out_o.blue  = blue_q;

`ifndef SYNTHESIS
  // No shade computed from v can exceed v
  a_shade_le_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (s4_p_q <= s4_bri_q) && (s4_q_q <= s4_bri_q) && (s4_t_q <= s4_bri_q))
    else $error("shade exceeds value");

  // A new output word must come from a valid stage 4 word
  a_out_from_stage4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && !$past(v5_q)) |-> $past(v4_q))
    else $error("output valid without source word");

  // Input is only refused when every stage holds a word
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (v1_q && v2_q && v3_q && v4_q && v5_q))
    else $error("input stalled with a free stage");
`endif

endmodule
